>>> sv/fpd_pkg.sv
// Shared types and constants of the frame prefetch dispatcher.
// Holds the controller state enum, the command and status structs and record codes.
// No dependencies.
`timescale 1ns / 1ps

package fpd_pkg;

    localparam int FRAME_W     = 32;
    localparam int CFG_W       = 10;
    localparam int MAX_RECORDS = 10;
    localparam int REC_CNT_W   = 4;

    localparam logic [2:0] KIND_ASSIGN   = 3'd0;
    localparam logic [2:0] KIND_READY    = 3'd1;
    localparam logic [2:0] KIND_PROGRESS = 3'd2;
    localparam logic [2:0] KIND_PENDING  = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    localparam logic CFG_NEAR_WINDOW    = 1'b0;
    localparam logic CFG_STALE_DISTANCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DONE_RD,
        ST_DONE_EMIT,
        ST_SCAN_RD,
        ST_SCAN_EXE,
        ST_STATUS,
        ST_PASS_INIT,
        ST_PASS_RD,
        ST_PASS_EXE,
        ST_PASS_END,
        ST_PEND,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept_req;
        logic accept_done;
        logic start_pend;
        logic idx_inc;
        logic scan_step;
        logic emit_status;
        logic pass_init;
        logic pass_take;
        logic flip_dir;
        logic clear_pend;
        logic set_pend;
        logic emit_done;
        logic flush;
    } cmd_t;

    typedef struct packed {
        logic w_ok;
        logic idx_last;
        logic pend_valid;
        logic has_status;
        logic need;
        logic take;
        logic second;
        logic can_emit;
        logic out_free;
        logic hold_valid;
        logic is_req;
    } stat_t;

endpackage

>>> sv/fpd_ctrl.sv
// Controller of the frame prefetch dispatcher: sequences scan, passes and records.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          req_type,
    input  fpd_pkg::stat_t st,
    output fpd_pkg::cmd_t cmd
);
    import fpd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (!req_type)
                    begin
                        cmd.accept_req = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                    else if (st.w_ok)
                    begin
                        cmd.accept_done = 1'b1;
                        state_next      = ST_DONE_RD;
                    end
                end
            end
            ST_DONE_RD:
            begin
                state_next = ST_DONE_EMIT;
            end
            ST_DONE_EMIT:
            begin
                if (st.can_emit)
                begin
                    cmd.emit_done = 1'b1;
                    if (st.pend_valid)
                    begin
                        cmd.start_pend = 1'b1;
                        state_next     = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_EXE;
            end
            ST_SCAN_EXE:
            begin
                cmd.scan_step = 1'b1;
                if (st.idx_last)
                begin
                    state_next = st.is_req ? ST_STATUS : ST_PASS_INIT;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SCAN_RD;
                end
            end
            ST_STATUS:
            begin
                if (!st.has_status)
                begin
                    state_next = ST_PASS_INIT;
                end
                else if (st.can_emit)
                begin
                    cmd.emit_status = 1'b1;
                    state_next      = ST_PASS_INIT;
                end
            end
            ST_PASS_INIT:
            begin
                cmd.pass_init = 1'b1;
                state_next    = ST_PASS_RD;
            end
            ST_PASS_RD:
            begin
                state_next = ST_PASS_EXE;
            end
            ST_PASS_EXE:
            begin
                if (!st.take || st.can_emit)
                begin
                    cmd.pass_take = st.take;
                    if (st.idx_last)
                    begin
                        state_next = ST_PASS_END;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_PASS_RD;
                    end
                end
            end
            ST_PASS_END:
            begin
                if (!st.need)
                begin
                    cmd.clear_pend = !st.is_req;
                    state_next     = ST_FINISH;
                end
                else if (!st.second)
                begin
                    cmd.flip_dir = 1'b1;
                    state_next   = ST_PASS_INIT;
                end
                else
                begin
                    state_next = ST_PEND;
                end
            end
            ST_PEND:
            begin
                if (st.can_emit)
                begin
                    cmd.set_pend = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!st.hold_valid)
                begin
                    state_next = ST_IDLE;
                end
                else if (st.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/fpd_datapath.sv
// Datapath of the frame prefetch dispatcher: worker table, scan and pass logic,
// record staging and output register. Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_datapath #(
    parameter int NUM_WORKERS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  fpd_pkg::cmd_t                      cmd,
    output fpd_pkg::stat_t                     st,
    input  logic signed [fpd_pkg::FRAME_W-1:0] frame_number,
    input  logic [2:0]                         worker_id,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [fpd_pkg::CFG_W-1:0]          cfg_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         kind,
    output logic [2:0]                         worker_index,
    output logic signed [fpd_pkg::FRAME_W-1:0] frame,
    output logic                               last_record
);
    import fpd_pkg::*;

    localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

    logic [FRAME_W-1:0]    wf_mem [NUM_WORKERS];
    logic [NUM_WORKERS-1:0] wf_written_reg;
    logic [NUM_WORKERS-1:0] busy_reg;
    logic signed [FRAME_W-1:0] rd_frame_reg;

    logic [CFG_W-1:0] near_reg;
    logic [CFG_W-1:0] stale_reg;

    logic signed [FRAME_W-1:0] last_req_reg;
    logic                      pend_valid_reg;
    logic signed [FRAME_W-1:0] pend_frame_reg;
    logic                      pend_back_reg;

    logic signed [FRAME_W-1:0] n_reg;
    logic                      dir_reg;
    logic                      orig_dir_reg;
    logic                      need_reg;
    logic                      second_reg;
    logic                      is_req_reg;
    logic [IW-1:0]             idx_reg;
    logic signed [FRAME_W-1:0] nmax_reg;
    logic signed [FRAME_W-1:0] nmin_reg;
    logic                      inb_reg;
    logic                      inf_reg;
    logic                      nb_reg;
    logic signed [FRAME_W-1:0] next_reg;
    logic                      busy_f_reg;
    logic [IW-1:0]             busy_idx_reg;
    logic                      hit_f_reg;
    logic [IW-1:0]             hit_idx_reg;

    logic [REC_CNT_W-1:0]      rec_count_reg;
    logic                      hold_valid_reg;
    logic [2:0]                hold_kind_reg;
    logic [2:0]                hold_idx_reg;
    logic signed [FRAME_W-1:0] hold_frame_reg;

    logic                      out_valid_reg;
    logic [2:0]                out_kind_reg;
    logic [2:0]                out_idx_reg;
    logic signed [FRAME_W-1:0] out_frame_reg;
    logic                      out_last_reg;

    logic signed [FRAME_W:0]   diff;
    logic signed [FRAME_W:0]   adiff;
    logic signed [FRAME_W:0]   near_ext;
    logic signed [FRAME_W:0]   stale_ext;
    logic                      is_near;
    logic                      eligible;
    logic signed [FRAME_W-1:0] step;
    logic signed [FRAME_W-1:0] n_step;
    logic signed [FRAME_W-1:0] take_frame;
    logic                      emit;
    logic                      emit_keep;
    logic [2:0]                rec_kind;
    logic [2:0]                rec_idx;
    logic signed [FRAME_W-1:0] rec_frame;
    logic                      out_free;

    assign diff      = {rd_frame_reg[FRAME_W-1], rd_frame_reg} - {n_reg[FRAME_W-1], n_reg};
    assign adiff     = (diff < 0) ? -diff : diff;
    assign near_ext  = $signed({{(FRAME_W + 1 - CFG_W){1'b0}}, near_reg});
    assign stale_ext = $signed({{(FRAME_W + 1 - CFG_W){1'b0}}, stale_reg});
    assign is_near   = (adiff < near_ext);
    assign step      = dir_reg ? -32'sd1 : 32'sd1;
    assign n_step    = n_reg + step;

    always_comb
    begin
        if (dir_reg)
        begin
            eligible = (rd_frame_reg >= n_reg) || (-diff > stale_ext);
        end
        else
        begin
            eligible = (rd_frame_reg <= n_reg) || (diff > stale_ext);
        end
    end

    always_comb
    begin
        if (need_reg)
        begin
            take_frame = n_reg;
        end
        else if (!nb_reg)
        begin
            take_frame = n_step;
        end
        else
        begin
            take_frame = next_reg;
        end
    end

    // One record source is active at a time; the controller sequences them.
    always_comb
    begin
        rec_kind  = KIND_ASSIGN;
        rec_idx   = 3'(idx_reg);
        rec_frame = take_frame;
        if (cmd.emit_done)
        begin
            rec_kind  = KIND_DONE;
            rec_frame = rd_frame_reg;
        end
        else if (cmd.emit_status)
        begin
            rec_kind  = busy_f_reg ? KIND_PROGRESS : KIND_READY;
            rec_idx   = busy_f_reg ? 3'(busy_idx_reg) : 3'(hit_idx_reg);
            rec_frame = n_reg;
        end
        else if (cmd.set_pend)
        begin
            rec_kind  = KIND_PENDING;
            rec_idx   = 3'd0;
            rec_frame = n_reg;
        end
    end

    assign emit      = cmd.emit_done || cmd.emit_status || cmd.pass_take || cmd.set_pend;
    assign emit_keep = emit && (rec_count_reg < REC_CNT_W'(MAX_RECORDS));
    assign out_free  = !out_valid_reg || !out_stall;

    assign st.w_ok       = (32'(worker_id) < NUM_WORKERS);
    assign st.idx_last   = (32'(idx_reg) == NUM_WORKERS - 1);
    assign st.pend_valid = pend_valid_reg;
    assign st.has_status = busy_f_reg || hit_f_reg;
    assign st.need       = need_reg;
    assign st.take       = !busy_reg[idx_reg] && eligible;
    assign st.second     = second_reg;
    assign st.can_emit   = (rec_count_reg >= REC_CNT_W'(MAX_RECORDS)) || !hold_valid_reg
                           || out_free;
    assign st.out_free   = out_free;
    assign st.hold_valid = hold_valid_reg;
    assign st.is_req     = is_req_reg;

    // Worker frame table with a registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.pass_take)
        begin
            wf_mem[idx_reg] <= take_frame;
        end
        rd_frame_reg <= wf_written_reg[idx_reg] ? $signed(wf_mem[idx_reg]) : -32'sd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wf_written_reg <= '0;
            busy_reg       <= '0;
            near_reg       <= CFG_W'(32);
            stale_reg      <= CFG_W'(20);
            last_req_reg   <= -32'sd1;
            pend_valid_reg <= 1'b0;
            pend_frame_reg <= '0;
            pend_back_reg  <= 1'b0;
            rec_count_reg  <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NEAR_WINDOW:    near_reg  <= cfg_data;
                    CFG_STALE_DISTANCE: stale_reg <= cfg_data;
                    default:            near_reg  <= near_reg;
                endcase
            end
            if (cmd.accept_req)
            begin
                last_req_reg   <= frame_number;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.clear_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.set_pend)
            begin
                pend_valid_reg <= 1'b1;
                pend_frame_reg <= n_reg;
                pend_back_reg  <= orig_dir_reg;
            end
            if (cmd.emit_done)
            begin
                busy_reg[idx_reg] <= 1'b0;
            end
            if (cmd.pass_take)
            begin
                busy_reg[idx_reg]       <= 1'b1;
                wf_written_reg[idx_reg] <= 1'b1;
            end

            if (cmd.accept_req || cmd.accept_done)
            begin
                rec_count_reg <= '0;
            end
            else if (emit_keep)
            begin
                rec_count_reg <= rec_count_reg + 1'b1;
            end

            if ((emit_keep && hold_valid_reg) || cmd.flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (emit_keep)
            begin
                hold_valid_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the staged record and the output record.
    always_ff @(posedge clk)
    begin
        if (emit_keep)
        begin
            hold_kind_reg  <= rec_kind;
            hold_idx_reg   <= rec_idx;
            hold_frame_reg <= rec_frame;
        end
        if ((emit_keep && hold_valid_reg) || cmd.flush)
        begin
            out_kind_reg  <= hold_kind_reg;
            out_idx_reg   <= hold_idx_reg;
            out_frame_reg <= hold_frame_reg;
            out_last_reg  <= cmd.flush;
        end
    end

    // Per-item working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_req || cmd.start_pend)
        begin
            n_reg        <= cmd.accept_req ? frame_number : pend_frame_reg;
            dir_reg      <= cmd.accept_req ? (last_req_reg > frame_number) : pend_back_reg;
            orig_dir_reg <= cmd.accept_req ? (last_req_reg > frame_number) : pend_back_reg;
            nmax_reg     <= cmd.accept_req ? frame_number : pend_frame_reg;
            nmin_reg     <= cmd.accept_req ? frame_number : pend_frame_reg;
            is_req_reg   <= cmd.accept_req;
            need_reg     <= 1'b1;
            second_reg   <= 1'b0;
            idx_reg      <= '0;
            inb_reg      <= 1'b0;
            inf_reg      <= 1'b0;
            busy_f_reg   <= 1'b0;
            hit_f_reg    <= 1'b0;
        end
        else if (cmd.accept_done)
        begin
            idx_reg    <= IW'(worker_id);
            is_req_reg <= 1'b0;
        end
        else
        begin
            if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.scan_step)
            begin
                if (rd_frame_reg > nmax_reg && is_near)
                begin
                    nmax_reg <= rd_frame_reg;
                end
                if (rd_frame_reg < nmin_reg && is_near)
                begin
                    nmin_reg <= rd_frame_reg;
                end
                if (rd_frame_reg == n_reg - 32'sd1)
                begin
                    inb_reg <= 1'b1;
                end
                if (rd_frame_reg == n_reg + 32'sd1)
                begin
                    inf_reg <= 1'b1;
                end
                if (rd_frame_reg == n_reg)
                begin
                    if (busy_reg[idx_reg])
                    begin
                        busy_f_reg   <= 1'b1;
                        busy_idx_reg <= idx_reg;
                    end
                    else
                    begin
                        hit_f_reg   <= 1'b1;
                        hit_idx_reg <= idx_reg;
                    end
                end
            end
            if (cmd.emit_status)
            begin
                need_reg <= 1'b0;
            end
            if (cmd.pass_init)
            begin
                idx_reg  <= '0;
                next_reg <= (dir_reg ? nmin_reg : nmax_reg) + step;
                nb_reg   <= dir_reg ? inb_reg : inf_reg;
            end
            if (cmd.flip_dir)
            begin
                dir_reg    <= !dir_reg;
                second_reg <= 1'b1;
            end
            if (cmd.pass_take)
            begin
                if (need_reg)
                begin
                    need_reg <= 1'b0;
                end
                else if (!nb_reg)
                begin
                    nb_reg <= 1'b1;
                    if (next_reg == n_step)
                    begin
                        next_reg <= next_reg + step;
                    end
                end
                else
                begin
                    next_reg <= next_reg + step;
                end
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_kind_reg;
    assign worker_index = out_idx_reg;
    assign frame        = out_frame_reg;
    assign last_record  = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rec_count_reg <= REC_CNT_W'(MAX_RECORDS))
        else $error("record count beyond limit");

    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pass_take |-> !busy_reg[idx_reg])
        else $error("assignment to a busy worker");

    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_keep && hold_valid_reg) |-> out_free)
        else $error("record staged while output register is full");

endmodule

>>> sv/frame_prefetch_dispatcher.sv
// Frame prefetch dispatcher: one item at a time, each worker visit in a read state and
// an execute state since the worker table has a registered read port. A request scans
// the workers and makes one pass, or a second pass and a pending record; a done event
// retries a pending request with a scan and passes. Output stalls lengthen both.
// Reset (async, active low) idles all workers with frame minus one and clears the
// pending request; config returns to near window 32 and stale distance 20.
`timescale 1ns / 1ps

module frame_prefetch_dispatcher #(
    parameter int NUM_WORKERS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               req_type,
    input  logic signed [fpd_pkg::FRAME_W-1:0] frame_number,
    input  logic [2:0]                         worker_id,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [2:0]                         kind,
    output logic [2:0]                         worker_index,
    output logic signed [fpd_pkg::FRAME_W-1:0] frame,
    output logic                               last_record,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [fpd_pkg::CFG_W-1:0]          cfg_data
);
    import fpd_pkg::*;

    cmd_t  cmd;
    stat_t st;

    fpd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .req_type (req_type),
        .st       (st),
        .cmd      (cmd)
    );

    fpd_datapath #(
        .NUM_WORKERS (NUM_WORKERS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .st           (st),
        .frame_number (frame_number),
        .worker_id    (worker_id),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .worker_index (worker_index),
        .frame        (frame),
        .last_record  (last_record)
    );

endmodule

>>> tb/fpd_checker.sv
// Checker for the frame prefetch dispatcher: tracks worker state from accepted transfers,
// predicts the result records of each input and compares them field by field.
// Depends on fpd_pkg.
`timescale 1ns / 1ps

module fpd_checker #(
    parameter int NUM_WORKERS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        req_type,
    input  logic [31:0] frame_number,
    input  logic [2:0]  worker_id,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  kind,
    input  logic [2:0]  worker_index,
    input  logic [31:0] frame,
    input  logic        last_record,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [9:0]  cfg_data,
    output int          fail_count,
    output int          records_seen,
    output int          records_waiting
);
    import fpd_pkg::*;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  worker;
        logic [31:0] frame;
        logic        last;
    } record_t;

    logic [31:0] wk_frame [NUM_WORKERS];
    logic        wk_busy [NUM_WORKERS];
    logic [31:0] prev_req;
    logic        pend_valid;
    logic [31:0] pend_frame;
    logic        pend_back;
    logic [9:0]  near_win;
    logic [9:0]  stale_dist;
    record_t     expected_records[$];
    record_t     step_records[$];

    assign records_waiting = expected_records.size();

    function automatic void add_record(logic [2:0] k, int w, logic [31:0] f);
        record_t r;
        r.kind = k;
        r.worker = w[2:0];
        r.frame = f;
        r.last = 1'b0;
        if (step_records.size() < MAX_RECORDS)
            step_records.push_back(r);
    endfunction

    // Returns 1 when frame n no longer needs a worker.
    function automatic bit assign_workers(logic [31:0] n, bit back, bit need);
        logic signed [31:0] sn, sf, nmax, nmin;
        longint d, ad;
        int inb, inf, nb;
        logic [31:0] stp, nxt;
        bit take;
        sn = n;
        nmax = n;
        nmin = n;
        inb = -1;
        inf = -1;
        for (int i = 0; i < NUM_WORKERS; i++) begin
            sf = wk_frame[i];
            d = longint'(sf) - longint'(sn);
            ad = d < 0 ? -d : d;
            if (sf > nmax && ad < longint'(near_win)) nmax = sf;
            if (sf < nmin && ad < longint'(near_win)) nmin = sf;
            if (wk_frame[i] == n - 32'd1) inb = i;
            if (wk_frame[i] == n + 32'd1) inf = i;
        end
        for (int p = 0; p < 2; p++) begin
            stp = back ? 32'hFFFF_FFFF : 32'd1;
            nxt = (back ? nmin : nmax) + stp;
            nb = back ? inb : inf;
            for (int i = 0; i < NUM_WORKERS; i++) begin
                if (wk_busy[i]) continue;
                sf = wk_frame[i];
                if (back)
                    take = sf >= sn || longint'(sn) - longint'(sf) > longint'(stale_dist);
                else
                    take = sf <= sn || longint'(sf) - longint'(sn) > longint'(stale_dist);
                if (!take) continue;
                wk_busy[i] = 1'b1;
                if (need) begin
                    wk_frame[i] = n;
                    need = 0;
                end else if (nb < 0) begin
                    nb = i;
                    wk_frame[i] = n + stp;
                    if (nxt == n + stp) nxt += stp;
                end else begin
                    wk_frame[i] = nxt;
                    nxt += stp;
                end
                add_record(KIND_ASSIGN, i, wk_frame[i]);
            end
            if (!need) break;
            back = !back;
        end
        return !need;
    endfunction

    function automatic void predict_transfer(logic rt, logic [31:0] n, logic [2:0] w);
        int hit, busy;
        bit back;
        record_t r;
        step_records.delete();
        if (rt == 1'b0) begin
            back = $signed(prev_req) > $signed(n);
            prev_req = n;
            pend_valid = 1'b0;
            hit = -1;
            busy = -1;
            for (int i = 0; i < NUM_WORKERS; i++)
                if (wk_frame[i] == n) begin
                    if (wk_busy[i]) busy = i;
                    else hit = i;
                end
            if (busy >= 0) add_record(KIND_PROGRESS, busy, n);
            else if (hit >= 0) add_record(KIND_READY, hit, n);
            if (!assign_workers(n, back, busy < 0 && hit < 0)) begin
                pend_valid = 1'b1;
                pend_frame = n;
                pend_back = back;
                add_record(KIND_PENDING, 0, n);
            end
        end else begin
            if (int'(w) >= NUM_WORKERS) return;
            wk_busy[w] = 1'b0;
            add_record(KIND_DONE, w, wk_frame[w]);
            if (pend_valid) begin
                if (assign_workers(pend_frame, pend_back, 1))
                    pend_valid = 1'b0;
                else
                    add_record(KIND_PENDING, 0, pend_frame);
            end
        end
        for (int i = 0; i < step_records.size(); i++) begin
            r = step_records[i];
            r.last = (i == step_records.size() - 1);
            expected_records.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n) begin
        record_t e;
        if (!rst_n) begin
            for (int i = 0; i < NUM_WORKERS; i++) begin
                wk_frame[i] = 32'hFFFF_FFFF;
                wk_busy[i] = 1'b0;
            end
            prev_req = 32'hFFFF_FFFF;
            pend_valid = 1'b0;
            pend_frame = '0;
            pend_back = 1'b0;
            near_win = 10'd32;
            stale_dist = 10'd20;
            expected_records.delete();
            fail_count = 0;
            records_seen = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_NEAR_WINDOW) near_win = cfg_data;
                else stale_dist = cfg_data;
            end
            if (out_valid && !out_stall) begin
                records_seen++;
                if (expected_records.size() == 0) begin
                    $display("%0t: unexpected record kind %0d worker %0d frame %0d last %0d",
                             $time, kind, worker_index, $signed(frame), last_record);
                    fail_count++;
                end else begin
                    e = expected_records.pop_front();
                    if (e.kind !== kind || e.worker !== worker_index || e.frame !== frame
                        || e.last !== last_record) begin
                        $display("%0t: mismatch expected kind %0d worker %0d frame %0d last %0d",
                                 $time, e.kind, e.worker, $signed(e.frame), e.last);
                        $display("%0t:          actual kind %0d worker %0d frame %0d last %0d",
                                 $time, kind, worker_index, $signed(frame), last_record);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                predict_transfer(req_type, frame_number, worker_id);
        end
    end

endmodule

>>> tb/tb.sv
// Testbench top for the frame prefetch dispatcher: makes stimulus and config phases,
// stalls the output side and gives the verdict. Depends on fpd_pkg and fpd_checker.
`timescale 1ns / 1ps

module tb;
    import fpd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [31:0] frame_number;
    logic [2:0]  worker_id;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  kind;
    logic [2:0]  worker_index;
    logic [31:0] frame;
    logic        last_record;
    logic        cfg_we;
    logic        cfg_index;
    logic [9:0]  cfg_data;
    int          fail_count;
    int          records_seen;
    int          records_waiting;
    int          idle_cycles;
    int          sent;
    int          stall_mode;
    logic [31:0] base_frame;

    frame_prefetch_dispatcher u_top (.*);

    fpd_checker u_chk (.*);

    initial begin
        clk = 1'b0;
        forever
        begin
            #6 clk = 1'b1;
            #6 clk = 1'b0;
        end
    end

    // Receiver stall pattern: changes mode now and then, including runs with no stall.
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // The stall is registered, so its value at the falling edge decides the next transfer.
    task automatic send_item(logic rt, logic [31:0] n, logic [2:0] w);
        @(negedge clk);
        in_valid <= 1'b1;
        req_type <= rt;
        frame_number <= n;
        worker_id <= w;
        while (in_stall) @(negedge clk);
        @(posedge clk);
        sent++;
        // Bursts: usually keep valid high, sometimes drop it for a gap.
        if ($urandom_range(0, 4) == 0) begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (records_waiting != 0) @(negedge clk);
        repeat (4 * 8 + 20) @(negedge clk);
    endtask

    task automatic write_config(logic idx, logic [9:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            send_item(1'b1, $urandom, 3'($urandom_range(0, 7)));
        else if (r < 85)
            send_item(1'b0, base_frame + $urandom_range(0, 60) - 30, 3'($urandom));
        else if (r < 93)
            send_item(1'b0, $urandom, 3'($urandom));
        else begin
            base_frame = $urandom;
            send_item(1'b0, base_frame, 3'($urandom));
        end
        if ($urandom_range(0, 9) == 0) base_frame = base_frame + $urandom_range(0, 8) - 4;
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        frame_number = '0;
        worker_id = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_NEAR_WINDOW;
        cfg_data = '0;
        stall_mode = 0;
        sent = 0;
        idle_cycles = 0;
        base_frame = 32'd100;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: forward run, hits, busy hits, pending and its retry on done.
        send_item(1'b0, 32'd0, 3'd0);
        send_item(1'b0, 32'd1, 3'd0);
        send_item(1'b0, 32'd1, 3'd0);
        for (int i = 0; i < 8; i++) send_item(1'b1, 32'd0, i[2:0]);
        send_item(1'b0, 32'd3, 3'd0);
        send_item(1'b0, 32'd3, 3'd0);
        send_item(1'b0, 32'd500, 3'd0);
        send_item(1'b1, 32'd0, 3'd2);
        send_item(1'b1, 32'd0, 3'd2);
        send_item(1'b0, 32'h7FFF_FFFF, 3'd7);
        send_item(1'b0, 32'h8000_0000, 3'd7);
        send_item(1'b1, 32'hFFFF_FFFF, 3'd5);
        send_item(1'b0, 32'hFFFF_FFFF, 3'd0);
        send_item(1'b1, 32'd0, 3'd7);
        drain_results();

        write_config(CFG_NEAR_WINDOW, 10'd1);
        write_config(CFG_STALE_DISTANCE, 10'd0);
        for (int i = 0; i < 120; i++) random_item();
        drain_results();

        write_config(CFG_NEAR_WINDOW, 10'd1023);
        write_config(CFG_STALE_DISTANCE, 10'd1023);
        for (int i = 0; i < 120; i++) random_item();
        drain_results();

        write_config(CFG_NEAR_WINDOW, 10'd7);
        write_config(CFG_STALE_DISTANCE, 10'd3);
        for (int i = 0; i < 120; i++) random_item();
        drain_results();

        $display("Sent %0d items over four register settings; %0d result records checked.",
                 sent, records_seen);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
